// File: hw/rtl/sfe_pkg.sv
// package for the four-digit segment frame encoder
// holds payload structs, command codes, queue entry type and segment tables
// no dependencies
`default_nettype none

package sfe_pkg;

  typedef enum logic [1:0] {
    CMD_SHOW  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_CTRL  = 2'd2
  } cmd_e;

  // request decoder states
  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } fstate_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [13:0] number;
    logic        colon_on;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       strobe_first;
    logic       last;
  } out_t;

  // one decoded request waiting for the byte sequencer
  typedef struct packed {
    logic            is_ctrl;
    logic [3:0][7:0] data;
  } entry_t;

  localparam logic [13:0] MAX_SHOWN = 14'd9999;
  localparam logic [7:0] COLON_BIT = 8'h80;
  localparam logic [7:0] CTRL_OFF = 8'h80;
  localparam logic [7:0] CTRL_ON = 8'h88;
  localparam logic [3:0][7:0] DIGIT_ADDR = {8'hC6, 8'hC4, 8'hC2, 8'hC0};

  function automatic logic [7:0] seg_of(logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h3f;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5b;
      4'd3:    seg = 8'h4f;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6d;
      4'd6:    seg = 8'h7d;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7f;
      4'd9:    seg = 8'h67;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  function automatic logic [7:0] ctrl_byte(logic [3:0] level);
    logic [3:0] dec;
    logic [7:0] b;
    dec = level - 4'd1;
    if (level == 4'd0) begin
      b = CTRL_OFF;
    end else begin
      b = CTRL_ON | {5'd0, dec[2:0]};
    end
    return b;
  endfunction

  // multiple of the decimal weight for conversion step 0, 1, 2
  function automatic logic [13:0] step_mult(logic [1:0] step, logic [3:0] m);
    logic [13:0] w;
    case (step)
      2'd0:    w = 14'd1000;
      2'd1:    w = 14'd100;
      default: w = 14'd10;
    endcase
    return w * {10'd0, m};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sfe_front.sv
// request decoder: accepts commands, converts numbers to segment bytes
// one digit per step, two on the last step; depends on sfe_pkg
`default_nettype none

module sfe_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire sfe_pkg::in_t    in_i,
  input  wire logic [3:0]      brightness_i,
  output logic                 busy_o,
  output logic                 push_o,
  output sfe_pkg::entry_t      entry_o,
  input  wire logic            full_i
);

  sfe_pkg::fstate_e state_q, state_d;
  logic [1:0]      step_q, step_d;
  logic [13:0]     rem_q, rem_d;
  logic            colon_q, colon_d;
  sfe_pkg::entry_t entry_q, entry_d;

  logic [3:0]  digit;
  logic [13:0] rem_next;
  logic [7:0]  colon_byte;

  // digit is the count of weight multiples not above the remainder
  always_comb begin
    digit = 4'd0;
    for (int m = 1; m <= 9; m++) begin
      if (rem_q >= sfe_pkg::step_mult(step_q, 4'(m))) begin
        digit = 4'(m);
      end
    end
    rem_next = rem_q - sfe_pkg::step_mult(step_q, digit);
  end

  assign colon_byte = colon_q ? sfe_pkg::COLON_BIT : 8'h00;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    rem_d   = rem_q;
    colon_d = colon_q;
    entry_d = entry_q;
    push_o  = 1'b0;
    case (state_q)
      sfe_pkg::F_IDLE: begin
        if (start_i) begin
          colon_d = in_i.colon_on;
          step_d  = 2'd0;
          rem_d   = (in_i.number > sfe_pkg::MAX_SHOWN) ? sfe_pkg::MAX_SHOWN : in_i.number;
          case (in_i.command)
            sfe_pkg::CMD_SHOW: begin
              entry_d.is_ctrl = 1'b0;
              state_d = sfe_pkg::F_CONV;
            end
            sfe_pkg::CMD_CLEAR: begin
              entry_d.is_ctrl = 1'b0;
              entry_d.data    = '0;
              state_d = sfe_pkg::F_PUSH;
            end
            sfe_pkg::CMD_CTRL: begin
              entry_d.is_ctrl = 1'b1;
              entry_d.data    = '0;
              entry_d.data[0] = sfe_pkg::ctrl_byte(brightness_i);
              state_d = sfe_pkg::F_PUSH;
            end
            default: begin
              state_d = sfe_pkg::F_IDLE;
            end
          endcase
        end
      end
      sfe_pkg::F_CONV: begin
        rem_d  = rem_next;
        step_d = step_q + 2'd1;
        case (step_q)
          2'd0: entry_d.data[0] = sfe_pkg::seg_of(digit) | colon_byte;
          2'd1: entry_d.data[1] = sfe_pkg::seg_of(digit) | colon_byte;
          default: begin
            entry_d.data[2] = sfe_pkg::seg_of(digit);
            entry_d.data[3] = sfe_pkg::seg_of(rem_next[3:0]);
            state_d = sfe_pkg::F_PUSH;
          end
        endcase
      end
      sfe_pkg::F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = sfe_pkg::F_IDLE;
        end
      end
      default: begin
        state_d = sfe_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfe_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    rem_q   <= rem_d;
    colon_q <= colon_d;
    entry_q <= entry_d;
  end

  assign busy_o  = (state_q != sfe_pkg::F_IDLE);
  assign entry_o = entry_q;

endmodule

`default_nettype wire

// File: hw/rtl/sfe_fifo.sv
// short show-ahead queue of decoded requests between decoder and sequencer
// depends on sfe_pkg
`default_nettype none

module sfe_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sfe_pkg::entry_t  wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output sfe_pkg::entry_t       rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  sfe_pkg::entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sfe_back.sv
// byte sequencer: turns queued requests into address and data frames
// one byte per cycle while busy, registered output; depends on sfe_pkg
`default_nettype none

module sfe_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire sfe_pkg::entry_t  entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  output sfe_pkg::out_t         out_o
);

  logic            active_q, active_d;
  logic [2:0]      beat_q, beat_d;
  sfe_pkg::entry_t cur_q, cur_d;
  logic            out_valid_q;
  sfe_pkg::out_t   out_q, out_d;
  logic            done;

  assign done  = active_q && (cur_q.is_ctrl || (beat_q == 3'd7));
  assign pop_o = (!active_q || done) && !empty_i;

  always_comb begin
    active_d = active_q;
    beat_d   = beat_q;
    cur_d    = cur_q;
    if (pop_o) begin
      active_d = 1'b1;
      beat_d   = 3'd0;
      cur_d    = entry_i;
    end else if (done) begin
      active_d = 1'b0;
    end else if (active_q) begin
      beat_d = beat_q + 3'd1;
    end

    // even beats send the address command, odd beats data, unless ctrl
    if (cur_q.is_ctrl) begin
      out_d.out_byte     = cur_q.data[0];
      out_d.strobe_first = 1'b1;
      out_d.last         = 1'b1;
    end else if (!beat_q[0]) begin
      out_d.out_byte     = sfe_pkg::DIGIT_ADDR[beat_q[2:1]];
      out_d.strobe_first = 1'b1;
      out_d.last         = 1'b0;
    end else begin
      out_d.out_byte     = cur_q.data[beat_q[2:1]];
      out_d.strobe_first = 1'b0;
      out_d.last         = (beat_q == 3'd7);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
    cur_q  <= cur_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/four_digit_segment_frame_encoder.sv
// top level of the four-digit segment frame encoder
// ties decoder, request queue and byte sequencer; depends on sfe_pkg
//
// usage: a request (command, number, colon_on on in_i) is taken on a clock
// edge with start_i high and busy_o low. show and clear produce eight bytes
// (address command with strobe, then data, for each of four digits); display
// control produces one byte; command code 3 produces nothing.
// results appear on out_o for one cycle each, marked by out_valid_o; the
// receiver cannot stall, so bytes leave one per cycle once a request starts.
// brightness is written through cfg_valid_i/cfg_data_i; cfg_ready_o is
// always high. it takes effect for display control requests accepted later.
// a show passes through three digit steps in the decoder, then the push
// into the queue, held while the queue is full; clear and display control
// go straight to the push. a free sequencer loads the entry from the queue
// into its current-entry register, then its output register drives out_o.
// shows and clears are paced by the sequencer's byte-per-cycle output,
// control by the decoder; the queue lets it work ahead while bytes go out.
// reset: queue empties, no output pending, brightness returns to 4.
`default_nettype none

module four_digit_segment_frame_encoder #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire sfe_pkg::in_t  in_i,
  output logic               out_valid_o,
  output sfe_pkg::out_t      out_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [3:0]    cfg_data_i
);

  logic [3:0]      brightness_q, brightness_d;
  logic            push, pop, full, empty;
  sfe_pkg::entry_t wr_entry, rd_entry;

  assign cfg_ready_o  = 1'b1;
  assign brightness_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : brightness_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= 4'd4;
    end else begin
      brightness_q <= brightness_d;
    end
  end

  sfe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .in_i        (in_i),
    .brightness_i(brightness_q),
    .busy_o      (busy_o),
    .push_o      (push),
    .entry_o     (wr_entry),
    .full_i      (full)
  );

  sfe_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(wr_entry),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(rd_entry)
  );

  sfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .entry_i    (rd_entry),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// File: verif/four_digit_segment_frame_encoder_test.sv
// testbench for four_digit_segment_frame_encoder: directed table, then random requests
// predicts or reads typed frames, checks each strobed byte field by field; depends on sfe_pkg
`default_nettype none

module four_digit_segment_frame_encoder_test;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned SHOW_LIMIT = 9999;
  localparam logic [7:0] ADDR_BASE = 8'hC0;
  localparam logic [7:0] CTRL_DARK = 8'h80;
  localparam logic [7:0] CTRL_LIT = 8'h88;
  localparam logic [7:0] COLON_SEG = 8'h80;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned DRAIN_GUARD = 5000;
  localparam int unsigned SEGMENTS = 6;
  localparam int unsigned SEGMENT_ITEMS = 26;

  typedef struct packed {
    logic [1:0]      command;
    logic [13:0]     number;
    logic            colon_on;
    logic            typed;
    logic [0:3][7:0] data;
    logic [7:0]      ctrl;
  } row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start_i = 1'b0;
  logic            busy_o;
  sfe_pkg::in_t    in_i = '0;
  logic            out_valid_o;
  sfe_pkg::out_t   out_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [3:0]      cfg_data_i = 4'd0;

  // typed expectation that rides along with the request on in_i
  logic            row_typed = 1'b0;
  logic [0:3][7:0] row_data = '0;
  logic [7:0]      row_ctrl = '0;

  sfe_pkg::out_t   frame_q[$];
  row_t            dir_rows[$];
  logic [3:0]      bright_model = 4'd4;
  sfe_pkg::out_t   got_exp;
  int              accept_count = 0;
  int              cfg_count = 0;
  int              err_count = 0;
  int              bytes_checked = 0;
  int              n_show = 0;
  int              n_clear = 0;
  int              n_ctrl = 0;
  int              n_unused = 0;

  four_digit_segment_frame_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [7:0] segment_pattern(input int unsigned digit);
    logic [7:0] p;
    case (digit)
      0:       p = 8'h3f;
      1:       p = 8'h06;
      2:       p = 8'h5b;
      3:       p = 8'h4f;
      4:       p = 8'h66;
      5:       p = 8'h6d;
      6:       p = 8'h7d;
      7:       p = 8'h07;
      8:       p = 8'h7f;
      default: p = 8'h67;
    endcase
    return p;
  endfunction

  function automatic void push_digit_frame(input logic [0:3][7:0] data);
    sfe_pkg::out_t b;
    for (int d = 0; d < 4; d++) begin
      b.out_byte = ADDR_BASE + 8'(2 * d);
      b.strobe_first = 1'b1;
      b.last = 1'b0;
      frame_q.push_back(b);
      b.out_byte = data[d];
      b.strobe_first = 1'b0;
      b.last = (d == 3);
      frame_q.push_back(b);
    end
  endfunction

  function automatic void push_ctrl_byte(input logic [7:0] ctrl);
    sfe_pkg::out_t b;
    b.out_byte = ctrl;
    b.strobe_first = 1'b1;
    b.last = 1'b1;
    frame_q.push_back(b);
  endfunction

  function automatic void predict_frames(input sfe_pkg::in_t req);
    int unsigned shown;
    logic [7:0] colon;
    logic [3:0] dec;
    logic [0:3][7:0] digs;
    colon = req.colon_on ? COLON_SEG : 8'h00;
    case (req.command)
      sfe_pkg::CMD_SHOW: begin
        // out-of-range numbers pin at the top value
        shown = (req.number > SHOW_LIMIT) ? SHOW_LIMIT : req.number;
        digs[0] = segment_pattern((shown / 1000) % 10) | colon;
        digs[1] = segment_pattern((shown / 100) % 10) | colon;
        digs[2] = segment_pattern((shown / 10) % 10);
        digs[3] = segment_pattern(shown % 10);
        push_digit_frame(digs);
      end
      sfe_pkg::CMD_CLEAR: push_digit_frame('0);
      sfe_pkg::CMD_CTRL: begin
        dec = bright_model - 4'd1;
        push_ctrl_byte((bright_model == 4'd0) ? CTRL_DARK : (CTRL_LIT | {5'd0, dec[2:0]}));
      end
      default: ;
    endcase
  endfunction

  // request and config bookkeeping, byte checking
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_model <= 4'd4;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        bright_model <= cfg_data_i;
        cfg_count <= cfg_count + 1;
      end
      if (out_valid_o === 1'b1) begin
        bytes_checked++;
        if (frame_q.size() == 0) begin
          note_mismatch($sformatf("unexpected byte %02h", out_o.out_byte));
        end else begin
          got_exp = frame_q.pop_front();
          if (out_o.out_byte !== got_exp.out_byte)
            note_mismatch($sformatf("out_byte %02h, want %02h", out_o.out_byte,
                                    got_exp.out_byte));
          if (out_o.strobe_first !== got_exp.strobe_first)
            note_mismatch($sformatf("strobe_first %b, want %b on byte %02h",
                                    out_o.strobe_first, got_exp.strobe_first,
                                    got_exp.out_byte));
          if (out_o.last !== got_exp.last)
            note_mismatch($sformatf("last %b, want %b on byte %02h", out_o.last,
                                    got_exp.last, got_exp.out_byte));
        end
      end
      if (start_i && !busy_o) begin
        accept_count <= accept_count + 1;
        case (in_i.command)
          sfe_pkg::CMD_SHOW:  n_show++;
          sfe_pkg::CMD_CLEAR: n_clear++;
          sfe_pkg::CMD_CTRL:  n_ctrl++;
          default:            n_unused++;
        endcase
        if (row_typed) begin
          case (in_i.command)
            sfe_pkg::CMD_SHOW, sfe_pkg::CMD_CLEAR: push_digit_frame(row_data);
            sfe_pkg::CMD_CTRL:                     push_ctrl_byte(row_ctrl);
            default: ;
          endcase
        end else begin
          predict_frames(in_i);
        end
      end
    end
  end

  function automatic row_t mk_row(input logic [1:0] cmd, input logic [13:0] num,
                                  input logic colon, input logic typed,
                                  input logic [0:3][7:0] data, input logic [7:0] ctrl);
    row_t r;
    r.command = cmd;
    r.number = num;
    r.colon_on = colon;
    r.typed = typed;
    r.data = data;
    r.ctrl = ctrl;
    return r;
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic issue_request(input sfe_pkg::in_t req, input logic typed,
                               input logic [0:3][7:0] data, input logic [7:0] ctrl);
    int seen;
    seen = accept_count;
    start_i <= 1'b1;
    in_i <= req;
    row_typed <= typed;
    row_data <= data;
    row_ctrl <= ctrl;
    do @(negedge clk_i); while (accept_count == seen);
  endtask

  task automatic write_brightness(input logic [3:0] level);
    int seen;
    seen = cfg_count;
    cfg_valid_i <= 1'b1;
    cfg_data_i <= level;
    do @(negedge clk_i); while (cfg_count == seen);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (frame_q.size() != 0 && guard < DRAIN_GUARD) begin
      @(negedge clk_i);
      guard++;
    end
    // an unused command leaves no trace in the queue and sends no bytes
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic sfe_pkg::in_t random_request();
    sfe_pkg::in_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) r.command = sfe_pkg::CMD_SHOW;
    else if (pick < 65) r.command = sfe_pkg::CMD_CLEAR;
    else if (pick < 85) r.command = sfe_pkg::CMD_CTRL;
    else r.command = CMD_UNUSED;
    if ($urandom_range(0, 99) < 20) r.number = 14'($urandom_range(0, 16383));
    else r.number = 14'($urandom_range(0, SHOW_LIMIT));
    r.colon_on = 1'($urandom_range(0, 1));
    return r;
  endfunction

  initial begin
    row_t         row;
    sfe_pkg::in_t req;
    int           idle_pct;
    logic [3:0]   levels [SEGMENTS];

    // typed rows: reset brightness, digit extremes, saturation, ignored fields
    dir_rows.push_back(mk_row(sfe_pkg::CMD_CTRL, 14'd0, 1'b0, 1'b1, '0, 8'h8B));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_SHOW, 14'd0, 1'b0, 1'b1, 32'h3f3f3f3f, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_SHOW, 14'd0, 1'b1, 1'b1, 32'hbfbf3f3f, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_SHOW, 14'd9999, 1'b0, 1'b1, 32'h67676767, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_SHOW, 14'd9999, 1'b1, 1'b1, 32'he7e76767, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_SHOW, 14'd10000, 1'b0, 1'b1, 32'h67676767, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_SHOW, 14'd16383, 1'b1, 1'b1, 32'he7e76767, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_CLEAR, 14'd16383, 1'b1, 1'b1, '0, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_CLEAR, 14'd0, 1'b0, 1'b1, '0, 8'h00));
    dir_rows.push_back(mk_row(CMD_UNUSED, 14'd1234, 1'b1, 1'b1, '0, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_CTRL, 14'd16383, 1'b1, 1'b1, '0, 8'h8B));
    dir_rows.push_back(mk_row(CMD_UNUSED, 14'd0, 1'b0, 1'b1, '0, 8'h00));
    // predicted rows
    dir_rows.push_back(mk_row(sfe_pkg::CMD_SHOW, 14'd1234, 1'b0, 1'b0, '0, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_SHOW, 14'd5678, 1'b1, 1'b0, '0, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_SHOW, 14'd9, 1'b0, 1'b0, '0, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_SHOW, 14'd1000, 1'b1, 1'b0, '0, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_SHOW, 14'd8080, 1'b0, 1'b0, '0, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_SHOW, 14'd4321, 1'b1, 1'b0, '0, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_SHOW, 14'd6789, 1'b0, 1'b0, '0, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_SHOW, 14'd9998, 1'b1, 1'b0, '0, 8'h00));
    dir_rows.push_back(mk_row(sfe_pkg::CMD_CTRL, 14'd42, 1'b0, 1'b0, '0, 8'h00));

    levels[0] = 4'd0;
    levels[1] = 4'd15;
    levels[2] = 4'd8;
    levels[3] = 4'd1;
    levels[4] = 4'd9;
    levels[5] = 4'($urandom_range(0, 15));

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      req.command = row.command;
      req.number = row.number;
      req.colon_on = row.colon_on;
      issue_request(req, row.typed, row.data, row.ctrl);
    end
    start_i <= 1'b0;
    row_typed <= 1'b0;

    for (int s = 0; s < SEGMENTS; s++) begin
      wait_drained();
      write_brightness(levels[s]);
      if (s < 2) idle_pct = 32;
      else if (s < 4) idle_pct = 53;
      else idle_pct = 0;
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        while ($urandom_range(0, 99) < idle_pct) begin
          start_i <= 1'b0;
          @(negedge clk_i);
        end
        issue_request(random_request(), 1'b0, '0, 8'h00);
      end
      start_i <= 1'b0;
    end

    wait_drained();
    if (frame_q.size() != 0)
      note_mismatch($sformatf("%0d expected bytes never arrived", frame_q.size()));

    $display("covered %0d requests: %0d show, %0d clear, %0d control, %0d unused code",
             accept_count, n_show, n_clear, n_ctrl, n_unused);
    $display("checked %0d bytes across %0d brightness writes", bytes_checked, cfg_count);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("timeout waiting for the encoder");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/sfe_pkg.sv
hw/rtl/sfe_front.sv
hw/rtl/sfe_fifo.sv
hw/rtl/sfe_back.sv
hw/rtl/four_digit_segment_frame_encoder.sv
verif/four_digit_segment_frame_encoder_test.sv
